// ----- design/seven_bit_line_folder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Seven-bit line folder assertion macros
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEVEN_BIT_LINE_FOLDER_TOP_ASSERT_SVH
`define SEVEN_BIT_LINE_FOLDER_TOP_ASSERT_SVH

// cond must hold at every edge out of reset
`define SBLF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// cons must hold whenever ante holds
`define SBLF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/sblf_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-bit line folder package
// Item types, codes, register map and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sblf_pkg;

	localparam int LINE_MAX_DEF = 62;
	localparam int LIMIT_W      = 6;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_FIRST_LIMIT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OTHER_LIMIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STRICT      = 2'd2;

	localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RST = 6'd62;
	localparam logic [LIMIT_W-1:0] OTHER_LIMIT_RST = 6'd62;
	localparam logic               STRICT_RST      = 1'b1;

	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_LINE_END = 2'd1;
	localparam logic [1:0] KIND_TEXT_END = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
	localparam logic [1:0] ERR_LONE_CR  = 2'd2;

	localparam logic [7:0] CH_CR         = 8'd13;
	localparam logic [7:0] CH_LF         = 8'd10;
	localparam logic [7:0] CH_SPACE      = 8'd32;
	localparam logic [7:0] CH_COMMA      = 8'd44;
	localparam logic [7:0] CH_SEMI       = 8'd59;
	localparam logic [7:0] STRICT_TOP    = 8'd126;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  out_byte;
		logic [15:0] blank_lines_before;
		logic [1:0]  error_code;
		logic        run_last;
	} out_item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] first_limit;
		logic [LIMIT_W-1:0] other_limit;
		logic               strict;
	} cfg_t;

	function automatic logic byte_allowed(input logic [7:0] b, input logic strict);
		logic ok;
		ok = (b != 8'd0) && (b != CH_CR) && (b != CH_LF);
		if (strict && (b > STRICT_TOP)) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_COMMA) || (b == CH_SEMI);
	endfunction

	// clamp a limit register into 1..lmax
	function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] v,
		input int lmax);
		logic [LIMIT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = LIMIT_W'(1);
		end
		if (int'(v) > lmax) begin
			r = LIMIT_W'(lmax);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/seven_bit_line_folder_top.sv -----
// ----------------------------------------------------------------------------
// Seven-bit line folder
// Checks text bytes against the 7-bit rule when strict and cuts them into
// output lines, folding after the last delimiter if the two line limits differ.
//
//   channel  | handshake                 | item
//   ---------+---------------------------+---------------------------------
//   byte     | byte_valid / byte_stall   | in_byte, end_of_text
//   res      | res_valid / res_stall     | kind, byte, blanks, error, last
//   cfg      | psel penable pwrite       | paddr 4*index, pwdata
//
// One item in flight. An item that causes results is held while each result
// is emitted and while the line-limit checks (after a filling or text-ending
// byte, and again after each fold) and the end-of-text check run.
// Asynchronous reset clears control state; the pending RAM is not cleared.
// byte_stall is high until the last result of the item is registered and its
// checks are done; res_stall on a waiting result keeps it high longer.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_bit_line_folder_top #(
	parameter int LINE_MAX = sblf_pkg::LINE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  sblf_pkg::in_item_t              byte_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output sblf_pkg::out_item_t             res_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sblf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sblf_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sblf_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	import sblf_pkg::*;

	`include "seven_bit_line_folder_top_assert.svh"

	localparam int CW = $clog2(LINE_MAX + 1);
	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CEM  = 4'd1;
	localparam logic [3:0] S_LOOP = 4'd2;
	localparam logic [3:0] S_LEND = 4'd3;
	localparam logic [3:0] S_EOT  = 4'd4;
	localparam logic [3:0] S_ERR  = 4'd5;
	localparam logic [3:0] S_EEND = 4'd6;

	cfg_t cfg;

	logic [3:0]    state_q;
	logic          eot_q;
	logic          cr_q;
	logic          in_error_q;
	logic          seen_q;
	logic          on_first_q;
	logic          started_q;
	logic          tail_q;
	logic          cont_lend_q;
	logic [CW-1:0] pc_q;
	logic [CW-1:0] ll_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   empty_q;
	logic [1:0]    err_q;
	logic          out_valid_q;
	out_item_t     out_item_q;
	logic          fwd_s1;
	logic [7:0]    fwd_byte_s1;
	logic [7:0]    ram_rdata;

	logic          acc;
	logic          out_free;
	logic [7:0]    b;
	logic          folding;
	logic          delim;
	logic          take;
	logic          commit_new;
	logic          fires;
	logic          fires1;
	logic          ewl_go;
	logic          wr_en;
	logic          rd_en;
	logic          emit;
	logic [CW-1:0] lim_f;
	logic [CW-1:0] lim_g;
	logic [CW-1:0] lim_now;
	logic [CW-1:0] ll1;
	logic [CW-1:0] pc1;
	logic [CW-1:0] idx_nx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [7:0]    rd_byte;
	logic [3:0]    after_in;
	logic [3:0]    after;
	out_item_t     emit_item;

	sblf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sblf_ram #(
		.WIDTH (8),
		.DEPTH (LINE_MAX)
	) u_pending (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (b),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign pready     = 1'b1;
	assign byte_stall = (state_q != S_IDLE);
	assign res_valid  = out_valid_q;
	assign res_item   = out_item_q;

	assign acc      = byte_valid && !byte_stall;
	assign out_free = !out_valid_q || !res_stall;
	assign b        = byte_item.in_byte;

	assign lim_f   = CW'(eff_limit(cfg.first_limit, LINE_MAX));
	assign lim_g   = CW'(eff_limit(cfg.other_limit, LINE_MAX));
	assign lim_now = on_first_q ? lim_f : lim_g;
	assign folding = (lim_f != lim_g);
	assign delim   = is_delim(b);

	assign ll1    = (ll_q < CW'(LINE_MAX)) ? ll_q + CW'(1) : ll_q;
	assign pc1    = (pc_q < CW'(LINE_MAX)) ? pc_q + CW'(1) : pc_q;
	assign idx_nx = CW'(idx_q) + CW'(1);
	assign fires  = (ll_q != '0) && (ll_q >= lim_now);
	assign fires1 = (ll1 >= lim_now);

	assign after_in = byte_item.end_of_text ? S_EOT : S_IDLE;
	assign after    = eot_q ? S_EOT : S_IDLE;

	assign take       = acc && !in_error_q && !cr_q && byte_allowed(b, cfg.strict);
	assign commit_new = take && (!folding || delim);

	// start of a whole-line end: flush pending bytes, then the line end
	assign ewl_go = (acc && !in_error_q && cr_q && (b == CH_LF) && (ll_q != '0))
		|| ((state_q == S_LOOP) && fires && !(folding && seen_q))
		|| ((state_q == S_EOT) && !in_error_q && !cr_q && (ll_q != '0));

	assign wr_en   = take && (pc_q < CW'(LINE_MAX));
	assign wr_addr = AW'(pc_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (commit_new || (ewl_go && (pc_q != '0))) begin
			rd_en = 1'b1;
		end else if ((state_q == S_CEM) && out_free && (idx_nx < pc_q)) begin
			rd_en   = 1'b1;
			rd_addr = AW'(idx_nx);
		end
	end

	assign rd_byte = fwd_s1 ? fwd_byte_s1 : ram_rdata;

	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			S_CEM: begin
				emit                         = out_free;
				emit_item.out_kind           = KIND_BYTE;
				emit_item.out_byte           = rd_byte;
				emit_item.blank_lines_before = started_q ? 16'd0 : empty_q;
				emit_item.run_last           = (idx_nx == pc_q) && !tail_q;
			end
			S_LOOP: begin
				emit               = out_free && fires && folding && seen_q;
				emit_item.out_kind = KIND_LINE_END;
				emit_item.run_last = !((pc_q != '0) && (pc_q >= lim_g)) && !eot_q;
			end
			S_LEND: begin
				emit               = out_free;
				emit_item.out_kind = KIND_LINE_END;
				emit_item.run_last = !eot_q;
			end
			S_ERR: begin
				emit                 = out_free;
				emit_item.out_kind   = KIND_ERROR;
				emit_item.error_code = err_q;
				emit_item.run_last   = !eot_q;
			end
			S_EEND: begin
				emit               = out_free;
				emit_item.out_kind = KIND_TEXT_END;
				emit_item.run_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_byte_s1 <= b;
		end
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eot_q       <= 1'b0;
			cr_q        <= 1'b0;
			in_error_q  <= 1'b0;
			seen_q      <= 1'b0;
			on_first_q  <= 1'b1;
			started_q   <= 1'b0;
			tail_q      <= 1'b0;
			cont_lend_q <= 1'b0;
			pc_q        <= '0;
			ll_q        <= '0;
			idx_q       <= '0;
			empty_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			if (rd_en) begin
				fwd_s1 <= wr_en && (wr_addr == rd_addr);
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						eot_q <= byte_item.end_of_text;
						if (in_error_q) begin
							state_q <= after_in;
						end else if (cr_q) begin
							cr_q <= 1'b0;
							if (b == CH_LF) begin
								if (ll_q == '0) begin
									if (empty_q != '1) begin
										empty_q <= empty_q + 16'd1;
									end
									on_first_q <= 1'b0;
									state_q    <= after_in;
								end
							end else begin
								err_q   <= ERR_LONE_CR;
								state_q <= S_ERR;
							end
						end else if (take) begin
							ll_q <= ll1;
							pc_q <= pc1;
							if (commit_new) begin
								idx_q       <= '0;
								tail_q      <= fires1 || byte_item.end_of_text;
								cont_lend_q <= 1'b0;
								seen_q      <= seen_q | (folding & delim);
								state_q     <= S_CEM;
							end else begin
								state_q <= (fires1 || byte_item.end_of_text) ? S_LOOP : S_IDLE;
							end
						end else if (b == CH_CR) begin
							cr_q    <= 1'b1;
							state_q <= after_in;
						end else begin
							err_q   <= ERR_BAD_CHAR;
							state_q <= S_ERR;
						end
					end
				end
				S_CEM: begin
					if (out_free) begin
						started_q <= 1'b1;
						empty_q   <= '0;
						if (idx_nx < pc_q) begin
							idx_q <= AW'(idx_nx);
						end else begin
							pc_q <= '0;
							if (cont_lend_q) begin
								state_q <= S_LEND;
							end else begin
								state_q <= tail_q ? S_LOOP : S_IDLE;
							end
						end
					end
				end
				S_LOOP: begin
					if (fires) begin
						// fold: the bytes after the delimiter start the next line
						if (folding && seen_q && out_free) begin
							ll_q       <= pc_q;
							seen_q     <= 1'b0;
							started_q  <= 1'b0;
							on_first_q <= 1'b0;
						end
					end else begin
						state_q <= after;
					end
				end
				S_LEND: begin
					if (out_free) begin
						ll_q       <= '0;
						seen_q     <= 1'b0;
						started_q  <= 1'b0;
						on_first_q <= 1'b0;
						state_q    <= after;
					end
				end
				S_EOT: begin
					if (in_error_q) begin
						state_q <= S_EEND;
					end else if (cr_q) begin
						err_q   <= ERR_LONE_CR;
						state_q <= S_ERR;
					end else if (ll_q == '0) begin
						state_q <= S_EEND;
					end
				end
				S_ERR: begin
					if (out_free) begin
						in_error_q <= 1'b1;
						cr_q       <= 1'b0;
						pc_q       <= '0;
						ll_q       <= '0;
						seen_q     <= 1'b0;
						started_q  <= 1'b0;
						state_q    <= after;
					end
				end
				S_EEND: begin
					if (out_free) begin
						pc_q       <= '0;
						ll_q       <= '0;
						seen_q     <= 1'b0;
						on_first_q <= 1'b1;
						cr_q       <= 1'b0;
						empty_q    <= '0;
						started_q  <= 1'b0;
						in_error_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (ewl_go) begin
				if (pc_q == '0) begin
					state_q <= S_LEND;
				end else begin
					idx_q       <= '0;
					tail_q      <= 1'b1;
					cont_lend_q <= 1'b1;
					state_q     <= S_CEM;
				end
			end
		end
	end

	`SBLF_ASSERT_IMPL(a_cem_idx, clk, arst_n, state_q == S_CEM, idx_nx <= pc_q, "pending read past count")
	`SBLF_ASSERT_IMPL(a_idle_pc, clk, arst_n, state_q == S_IDLE, pc_q <= ll_q, "pending count over line length")
	`SBLF_ASSERT_IMPL(a_err_quiet, clk, arst_n, in_error_q, state_q != S_CEM, "line byte after error")
	`SBLF_ASSERT_ALWAYS(a_cr_err, clk, arst_n, !(cr_q && in_error_q), "carriage return held in error")

endmodule

`default_nettype wire

// ----- design/sblf_ram.sv -----
// ----------------------------------------------------------------------------
// Seven-bit line folder RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sblf_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = sblf_pkg::LINE_MAX_DEF,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/sblf_regs.sv -----
// ----------------------------------------------------------------------------
// Seven-bit line folder configuration registers
// APB-style register file for the line limits and the strict check.
// ----------------------------------------------------------------------------
`default_nettype none

module sblf_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sblf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sblf_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sblf_pkg::APB_DATA_W-1:0] prdata,
	output sblf_pkg::cfg_t                  cfg
);

	import sblf_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_go;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_go   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_limit <= FIRST_LIMIT_RST;
			cfg_q.other_limit <= OTHER_LIMIT_RST;
			cfg_q.strict      <= STRICT_RST;
		end else if (wr_go) begin
			unique case (reg_idx)
				REG_FIRST_LIMIT: begin
					cfg_q.first_limit <= pwdata[LIMIT_W-1:0];
				end
				REG_OTHER_LIMIT: begin
					cfg_q.other_limit <= pwdata[LIMIT_W-1:0];
				end
				REG_STRICT: begin
					cfg_q.strict <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIRST_LIMIT: prdata = APB_DATA_W'(cfg_q.first_limit);
			REG_OTHER_LIMIT: prdata = APB_DATA_W'(cfg_q.other_limit);
			REG_STRICT:      prdata = APB_DATA_W'(cfg_q.strict);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- dv/tb_seven_bit_line_folder_top.sv -----
// ----------------------------------------------------------------------------
// Seven-bit line folder testbench
// Drives text bytes through the byte channel and checks every output item
// against an in-bench predictor of the 7-bit check, line breaking and folding.
// Register map readback, directed corner texts and random texts run in turn,
// with random idle cycles on the byte side and random stalls on the result
// side.
// ----------------------------------------------------------------------------

module tb_seven_bit_line_folder_top;

	import sblf_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 45;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_stall;
	in_item_t              byte_item;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	out_item_t             res_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	seven_bit_line_folder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// predictor state
	logic [7:0]     line_buf [LINE_MAX_DEF];
	int             buf_fill;
	int             cur_len;
	int             blank_run;
	logic           delim_in_line;
	logic           on_first;
	logic           cr_held;
	logic           text_started;
	logic           text_broken;
	logic [5:0]     first_lim;
	logic [5:0]     other_lim;
	logic           strict_mode;
	out_item_t      step_out[$];
	out_item_t      folded_stream[$];

	int   mismatches;
	int   items_sent;
	int   results_seen;
	int   reg_writes;
	int   idle_cycles;
	int   res_wait;
	logic calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int clamp_limit(input logic [5:0] v);
		if (v == 6'd0) return 1;
		if (int'(v) > LINE_MAX_DEF) return LINE_MAX_DEF;
		return int'(v);
	endfunction

	function automatic logic char_ok(input logic [7:0] b);
		if (b == 8'd0 || b == CH_CR || b == CH_LF) return 1'b0;
		if (strict_mode) return b <= STRICT_TOP;
		return 1'b1;
	endfunction

	function automatic logic fold_point(input logic [7:0] b);
		return b == CH_SPACE || b == CH_COMMA || b == CH_SEMI;
	endfunction

	function automatic void push_out(input logic [1:0] kind, input logic [7:0] b,
		input int blanks, input logic [1:0] err);
		out_item_t o;
		o.out_kind           = kind;
		o.out_byte           = b;
		o.blank_lines_before = 16'(blanks);
		o.error_code         = err;
		o.run_last           = 1'b0;
		step_out.insert(step_out.size(), o);
	endfunction

	function automatic void clear_text();
		buf_fill      = 0;
		cur_len       = 0;
		delim_in_line = 1'b0;
		on_first      = 1'b1;
		cr_held       = 1'b0;
		blank_run     = 0;
		text_started  = 1'b0;
		text_broken   = 1'b0;
	endfunction

	function automatic void flush_pending();
		for (int i = 0; i < buf_fill; i++) begin
			push_out(KIND_BYTE, line_buf[i], text_started ? 0 : blank_run, ERR_NONE);
			text_started = 1'b1;
			blank_run    = 0;
		end
		buf_fill = 0;
	endfunction

	function automatic void end_line();
		flush_pending();
		push_out(KIND_LINE_END, 8'd0, 0, ERR_NONE);
		cur_len       = 0;
		delim_in_line = 1'b0;
		text_started  = 1'b0;
		on_first      = 1'b0;
	endfunction

	function automatic void enter_error(input logic [1:0] code);
		push_out(KIND_ERROR, 8'd0, 0, code);
		text_broken   = 1'b1;
		cr_held       = 1'b0;
		buf_fill      = 0;
		cur_len       = 0;
		delim_in_line = 1'b0;
		text_started  = 1'b0;
	endfunction

	function automatic void take_char(input logic [7:0] b);
		int   f;
		int   g;
		int   lim;
		logic folding;
		f       = clamp_limit(first_lim);
		g       = clamp_limit(other_lim);
		folding = (f != g);
		if (buf_fill < LINE_MAX_DEF) begin
			line_buf[buf_fill] = b;
			buf_fill++;
		end
		if (cur_len < LINE_MAX_DEF) cur_len++;
		if (!folding) begin
			flush_pending();
		end else if (fold_point(b)) begin
			flush_pending();
			delim_in_line = 1'b1;
		end
		lim = on_first ? f : g;
		while (cur_len > 0 && cur_len >= lim) begin
			if (folding && delim_in_line) begin
				push_out(KIND_LINE_END, 8'd0, 0, ERR_NONE);
				cur_len       = buf_fill;
				delim_in_line = 1'b0;
				text_started  = 1'b0;
				on_first      = 1'b0;
			end else begin
				end_line();
			end
			lim = g;
		end
	endfunction

	function automatic void fold_step(input in_item_t it);
		logic [7:0] b;
		out_item_t  o;
		b = it.in_byte;
		step_out.delete();
		if (!text_broken) begin
			if (cr_held) begin
				cr_held = 1'b0;
				if (b == CH_LF) begin
					if (cur_len == 0) begin
						if (blank_run < 65535) blank_run++;
						on_first = 1'b0;
					end else begin
						end_line();
					end
				end else begin
					enter_error(ERR_LONE_CR);
				end
			end else if (char_ok(b)) begin
				take_char(b);
			end else if (b == CH_CR) begin
				cr_held = 1'b1;
			end else begin
				enter_error(ERR_BAD_CHAR);
			end
		end
		if (it.end_of_text) begin
			if (!text_broken) begin
				if (cr_held) enter_error(ERR_LONE_CR);
				else if (cur_len > 0) end_line();
			end
			push_out(KIND_TEXT_END, 8'd0, 0, ERR_NONE);
			clear_text();
		end
		if (step_out.size() > 0) begin
			o = step_out[step_out.size() - 1];
			o.run_last = 1'b1;
			step_out[step_out.size() - 1] = o;
		end
		foreach (step_out[i]) folded_stream.insert(folded_stream.size(), step_out[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 30) $display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int wait_draw();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (folded_stream.size() == 0) begin
			report_mismatch($sformatf("unexpected item kind %0d byte %0d",
				got.out_kind, got.out_byte));
		end else begin
			want = folded_stream.pop_front();
			if (got.out_kind !== want.out_kind)
				report_mismatch($sformatf("out_kind got %0d want %0d",
					got.out_kind, want.out_kind));
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte got %0d want %0d",
					got.out_byte, want.out_byte));
			if (got.blank_lines_before !== want.blank_lines_before)
				report_mismatch($sformatf("blank_lines_before got %0d want %0d",
					got.blank_lines_before, want.blank_lines_before));
			if (got.error_code !== want.error_code)
				report_mismatch($sformatf("error_code got %0d want %0d",
					got.error_code, want.error_code));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last got %0d want %0d",
					got.run_last, want.run_last));
		end
	endtask

	// result side: check and draw the next stall
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			check_result(res_item);
			res_wait = wait_draw();
		end
		if (res_wait > 0) begin
			res_stall <= 1'b1;
			res_wait--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall) ||
				(psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		in_item_t it;
		int       gap;
		it.in_byte     = b;
		it.end_of_text = eot;
		byte_item  <= it;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		fold_step(it);
		items_sent++;
		gap = wait_draw();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		while (folded_stream.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] shadow_reg(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_FIRST_LIMIT: return {26'd0, first_lim};
			REG_OTHER_LIMIT: return {26'd0, other_lim};
			REG_STRICT:      return {31'd0, strict_mode};
			default:         return 32'd0;
		endcase
	endfunction

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_FIRST_LIMIT: first_lim   = val[5:0];
			REG_OTHER_LIMIT: other_lim   = val[5:0];
			REG_STRICT:      strict_mode = val[0];
			default: ;
		endcase
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		if (got !== shadow_reg(idx))
			report_mismatch($sformatf("register %0d read %0h want %0h",
				idx, got, shadow_reg(idx)));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [5:0] f, input logic [5:0] g, input logic s);
		apb_write(REG_FIRST_LIMIT, {26'd0, f});
		apb_write(REG_OTHER_LIMIT, {26'd0, g});
		apb_write(REG_STRICT, {31'd0, s});
	endtask

	task automatic test_register_map();
		apb_read_check(REG_FIRST_LIMIT);
		apb_read_check(REG_OTHER_LIMIT);
		apb_read_check(REG_STRICT);
		apb_write(REG_SPARE, 32'hFFFF_FFFF);
		set_config(6'd63, 6'd0, 1'b0);
		apb_read_check(REG_FIRST_LIMIT);
		apb_read_check(REG_OTHER_LIMIT);
		apb_read_check(REG_STRICT);
		set_config(6'd62, 6'd62, 1'b1);
	endtask

	// reset limits, strict: extremes, CR LF, empty line, bad byte then ignored bytes
	task automatic test_strict_lines();
		send_byte(8'd1, 1'b0);
		send_byte(STRICT_TOP, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte("x", 1'b0);
		send_byte(8'd127, 1'b0);
		send_byte("y", 1'b1);
		settle();
	endtask

	// limits differ: fold after delimiters, lax high byte, lone CR, zero after error
	task automatic test_folding();
		set_config(6'd3, 6'd5, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte("b", 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte("c", 1'b0);
		send_byte("d", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte("z", 1'b0);
		send_byte(8'd0, 1'b1);
		settle();
	endtask

	// clamped limits, full line before CR LF, lone LF, CR as last byte
	task automatic test_tight_limits();
		set_config(6'd0, 6'd63, 1'b1);
		send_byte("q", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b1);
		send_byte(CH_SEMI, 1'b0);
		send_byte(CH_CR, 1'b1);
		settle();
	endtask

	// limit lowered under a line in progress
	task automatic test_limit_change();
		set_config(6'd62, 6'd62, 1'b1);
		send_byte("a", 1'b0);
		send_byte("b", 1'b0);
		send_byte("c", 1'b0);
		settle();
		set_config(6'd2, 6'd2, 1'b1);
		send_byte("d", 1'b0);
		send_byte("e", 1'b1);
		settle();
	endtask

	// widest line: a fold late in the first line, the rest closed at end of text
	task automatic test_full_line();
		set_config(6'd62, 6'd61, 1'b0);
		for (int i = 0; i < 64; i++)
			send_byte(i == 40 ? CH_SPACE : 8'(65 + i % 26), i == 63);
		settle();
	endtask

	function automatic logic [5:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd63;
			2: return 6'd62;
			3: return 6'd1;
			default: return 6'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return CH_SPACE;
		if (r < 12) return CH_COMMA;
		if (r < 18) return CH_SEMI;
		if (r < 92) return 8'($urandom_range(33, 126));
		if (r < 97) return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_text();
		int   len;
		logic noisy;
		len   = $urandom_range(1, 24);
		noisy = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			end else if (i < len - 1 && $urandom_range(0, 99) < 12) begin
				send_byte(CH_CR, 1'b0);
				i++;
				send_byte(CH_LF, i == len - 1);
			end else begin
				send_byte(pick_text_byte(), i == len - 1);
			end
		end
	endtask

	task automatic test_random_texts();
		int stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			settle();
			set_config(pick_limit(), pick_limit(), 1'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 4)) send_random_text();
		end
		calm = 1'b0;
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		byte_valid  = 1'b0;
		byte_item   = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		first_lim   = FIRST_LIMIT_RST;
		other_lim   = OTHER_LIMIT_RST;
		strict_mode = STRICT_RST;
		mismatches  = 0;
		items_sent  = 0;
		reg_writes  = 0;
		calm        = 1'b0;
		clear_text();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_map();
		test_strict_lines();
		test_folding();
		test_tight_limits();
		test_limit_change();
		test_full_line();
		test_random_texts();

		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d text bytes, %0d output items, %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("strict and lax checks, folding and plain breaks, errors, limit changes");
		if (folded_stream.size() > 0)
			report_mismatch($sformatf("%0d items never arrived", folded_stream.size()));
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
